// ===== src/bste_pkg.sv =====
package bste_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_HALF_DEF     = 4;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // One unit of tap weight; the center tap drops to 1 in exclude mode
  localparam int UNIT_WEIGHT = 1000;

  // Channels of one sample word
  localparam int NUM_CH = 3;
  localparam int CH_W   = 2;
  localparam logic [CH_W-1:0] CH_L = 2'd0;
  localparam logic [CH_W-1:0] CH_A = 2'd1;
  localparam logic [CH_W-1:0] CH_B = 2'd2;

  // Configuration port
  localparam int HALF_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MAC,
    ST_DRAIN,
    ST_DIV_GO,
    ST_DIV,
    ST_WRITE
  } bste_state_t;

  // Sequencer strobes to the datapath
  typedef struct packed {
    logic            mac_clear;
    logic            mac_step;
    logic            div_start;
    logic            res_load;
    logic            out_load;
    logic            run_end;
    logic [CH_W-1:0] ch;
  } bste_ctl_t;

  // Binomial coefficient by Pascal rows (elaboration only)
  function automatic int binom(int n, int i);
    int row [0:32];
    int r;
    int c;
    for (r = 0; r <= 32; r++) row[r] = 0;
    row[0] = 1;
    for (r = 1; r <= n; r++) begin
      for (c = r; c >= 1; c--) row[c] = row[c] + row[c-1];
    end
    return row[i];
  endfunction

  function automatic int wsum_norm(int k);
    return UNIT_WEIGHT * (1 << (2 * k));
  endfunction

  function automatic int wsum_excl(int k);
    return UNIT_WEIGHT * ((1 << (2 * k)) - binom(2 * k, k)) + 1;
  endfunction

  // Bits for the largest weight sum
  function automatic int weight_w(int max_half);
    return $clog2(UNIT_WEIGHT * (1 << (2 * max_half)) + 1);
  endfunction

endpackage

// ===== src/bste_window.sv =====
module bste_window import bste_pkg::*; #(
  parameter int MAX_HALF     = MAX_HALF_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int DEPTH = 2 * MAX_HALF + 1,
  localparam int IW    = $clog2(DEPTH),
  localparam int PW    = $clog2(3 * MAX_HALF + 1)
) (
  input  logic                           clk,
  input  logic                           in_fire,
  input  logic signed [SAMPLE_WIDTH-1:0] l_in,
  input  logic signed [SAMPLE_WIDTH-1:0] a_in,
  input  logic signed [SAMPLE_WIDTH-1:0] b_in,
  input  logic        [CH_W-1:0]         ch,
  input  logic        [PW-1:0]           pos,
  output logic signed [SAMPLE_WIDTH-1:0] sample
);

  // Position 0 holds the newest word
  logic signed [SAMPLE_WIDTH-1:0] store_r [NUM_CH][DEPTH];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int c = 0; c < NUM_CH; c++) begin
        for (int p = DEPTH - 1; p > 0; p--) store_r[c][p] <= store_r[c][p-1];
      end
      store_r[CH_L][0] <= l_in;
      store_r[CH_A][0] <= a_in;
      store_r[CH_B][0] <= b_in;
    end
  end

  // Taps past the store end read as zero
  always_comb begin
    if (int'(pos) < DEPTH) sample = store_r[ch][pos[IW-1:0]];
    else                   sample = '0;
  end

endmodule

// ===== src/bste_mac.sv =====
module bste_mac import bste_pkg::*; #(
  parameter int MAX_HALF     = MAX_HALF_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int KW = $clog2(MAX_HALF + 1),
  localparam int TW = $clog2(2 * MAX_HALF + 1),
  localparam int WW = weight_w(MAX_HALF),
  localparam int AW = SAMPLE_WIDTH + WW + 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bste_ctl_t                      ctl,
  input  logic        [KW-1:0]           k,
  input  logic        [TW-1:0]           tap,
  input  logic                           exclude,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic signed [AW-1:0]           acc,
  output logic        [WW-1:0]           wsum
);

  // Constant weight and weight-sum tables, row per half-width
  logic [WW-1:0] wtab [MAX_HALF+1][2*MAX_HALF+1];
  logic [WW-1:0] wsn  [MAX_HALF+1];
  logic [WW-1:0] wse  [MAX_HALF+1];

  for (genvar gk = 0; gk <= MAX_HALF; gk++) begin : g_row
    assign wsn[gk] = WW'(wsum_norm(gk));
    assign wse[gk] = WW'(wsum_excl(gk));
    for (genvar gi = 0; gi <= 2 * MAX_HALF; gi++) begin : g_tap
      assign wtab[gk][gi] = WW'((gi <= 2 * gk) ? UNIT_WEIGHT * binom(2 * gk, gi) : 0);
    end
  end

  logic [WW-1:0]        weight;
  logic signed [AW-1:0] prod_r;
  logic signed [AW-1:0] acc_r;
  logic                 pv_r;

  always_comb begin
    if (exclude && tap == TW'(k)) weight = WW'(1);
    else                          weight = wtab[k][tap];
  end

  assign wsum = exclude ? wse[k] : wsn[k];

  // Product register, then accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) pv_r <= 1'b0;
    else        pv_r <= ctl.mac_step & ~ctl.mac_clear;
  end

  always_ff @(posedge clk) begin
    prod_r <= AW'($signed({1'b0, weight})) * AW'(sample);
    if (ctl.mac_clear) acc_r <= '0;
    else if (pv_r)     acc_r <= acc_r + prod_r;
  end

  assign acc = acc_r;

endmodule

// ===== src/bste_div.sv =====
module bste_div import bste_pkg::*; #(
  parameter int MAX_HALF     = MAX_HALF_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int WW   = weight_w(MAX_HALF),
  localparam int AW   = SAMPLE_WIDTH + WW + 1,
  localparam int CNTW = $clog2(SAMPLE_WIDTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [AW-1:0]           acc,
  input  logic        [WW-1:0]           wsum,
  output logic                           done,
  output logic signed [SAMPLE_WIDTH-1:0] quot
);

  logic [WW:0]             rem_r;
  logic [SAMPLE_WIDTH-1:0] low_r;
  logic [WW-1:0]           den_r;
  logic                    neg_r;
  logic [CNTW-1:0]         cnt_r;
  logic                    busy_r;
  logic                    done_r;

  logic [AW-1:0]   mag;
  logic [AW-1:0]   num;
  logic [WW+1:0]   trial;
  logic [WW+1:0]   diff;
  logic            ge;

  // Magnitude plus half the divisor gives round-half-away
  assign mag   = acc[AW-1] ? AW'(-acc) : AW'(acc);
  assign num   = mag + AW'(wsum >> 1);
  assign trial = {rem_r, low_r[SAMPLE_WIDTH-1]};
  assign diff  = trial - {2'b00, den_r};
  assign ge    = trial >= {2'b00, den_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(SAMPLE_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Restoring radix-2 step; quotient shifts into low_r
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[AW-1:SAMPLE_WIDTH];
      low_r <= num[SAMPLE_WIDTH-1:0];
      den_r <= wsum;
      neg_r <= acc[AW-1];
    end else if (busy_r) begin
      rem_r <= ge ? diff[WW:0] : trial[WW:0];
      low_r <= {low_r[SAMPLE_WIDTH-2:0], ge};
    end
  end

  // Sign and saturate
  always_comb begin
    if (neg_r)                   quot = $signed(-low_r);
    else if (low_r[SAMPLE_WIDTH-1]) quot = $signed({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
    else                         quot = $signed(low_r);
  end

  assign done = done_r;

endmodule

// ===== src/bste_ctrl.sv =====
module bste_ctrl import bste_pkg::*; #(
  parameter int MAX_HALF = MAX_HALF_DEF,
  localparam int DEPTH = 2 * MAX_HALF + 1,
  localparam int KW    = $clog2(MAX_HALF + 1),
  localparam int TW    = $clog2(2 * MAX_HALF + 1),
  localparam int PW    = $clog2(3 * MAX_HALF + 1),
  localparam int CW    = $clog2(DEPTH + 1),
  localparam int NW    = $clog2(MAX_HALF + 2)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_final,
  input  logic [KW-1:0] h,
  input  logic          out_valid,
  input  logic          out_ready,
  input  logic          div_done,
  output bste_ctl_t     ctl,
  output logic [KW-1:0] k,
  output logic [TW-1:0] tap,
  output logic [PW-1:0] pos
);

  bste_state_t state_r, state_nxt;

  logic [CW-1:0] ss_r;
  logic [CW-1:0] og_r;
  logic [NW-1:0] cnt_r;
  logic          final_r;
  logic [KW-1:0] k_r;
  logic [TW-1:0] tap_r;
  logic [PW-1:0] pos_r;
  logic [PW-1:0] pos_start_r;
  logic [CH_W-1:0] ch_r;

  logic          in_fire;
  logic          out_free;
  logic          last_tap;
  logic          sat;
  logic [CW-1:0] newest;
  logic [CW-1:0] to_end;
  logic [CW-1:0] from_start;
  logic [CW-1:0] kk;
  logic [CW-1:0] pending;
  logic          emit;
  logic [PW-1:0] pos_first;

  assign in_fire  = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign last_tap = tap_r == TW'({k_r, 1'b0});

  // Next pending output and its tapered half-width
  always_comb begin
    sat        = ss_r == CW'(DEPTH);
    newest     = ss_r - 1'b1;
    to_end     = newest - og_r;
    from_start = sat ? CW'(MAX_HALF) : og_r;
    pending    = ss_r - og_r;
    kk         = CW'(h);
    if (from_start < kk) kk = from_start;
    if (to_end < kk)     kk = to_end;
    pos_first  = PW'(to_end) + PW'(kk);
    emit       = (og_r < ss_r) && (int'(cnt_r) < MAX_HALF + 1) &&
                 (final_r || pending > CW'(h));
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = emit ? ST_MAC : ST_IDLE;
      ST_MAC:    if (last_tap) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_DIV_GO;
      ST_DIV_GO: state_nxt = ST_DIV;
      ST_DIV:    if (div_done) state_nxt = (ch_r == CH_B) ? ST_WRITE : ST_MAC;
      ST_WRITE:  if (out_free) state_nxt = ST_CHECK;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = 1'b0;
    ctl           = '0;
    ctl.ch        = ch_r;
    ctl.run_end   = final_r && (og_r == newest);
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_CHECK:  ctl.mac_clear = emit;
      ST_MAC:    ctl.mac_step = 1'b1;
      ST_DIV_GO: ctl.div_start = 1'b1;
      ST_DIV: begin
        ctl.res_load  = div_done;
        ctl.mac_clear = div_done && (ch_r != CH_B);
      end
      ST_WRITE:  ctl.out_load = out_free;
      default:   in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Run counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ss_r    <= '0;
      og_r    <= '0;
      cnt_r   <= '0;
      final_r <= 1'b0;
    end else begin
      if (in_fire) begin
        final_r <= in_final;
        cnt_r   <= '0;
        if (ss_r < CW'(DEPTH))  ss_r <= ss_r + 1'b1;
        else if (og_r != '0)    og_r <= og_r - 1'b1;
      end else if (state_r == ST_CHECK && !emit && final_r) begin
        ss_r <= '0;
        og_r <= '0;
      end else if (ctl.out_load) begin
        og_r  <= og_r + 1'b1;
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Tap walk over the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= CH_L;
    end else if (state_r == ST_CHECK && emit) begin
      k_r         <= KW'(kk);
      pos_r       <= pos_first;
      pos_start_r <= pos_first;
      tap_r       <= '0;
      ch_r        <= CH_L;
    end else if (state_r == ST_MAC) begin
      tap_r <= tap_r + 1'b1;
      pos_r <= pos_r - 1'b1;
    end else if (ctl.mac_clear) begin
      tap_r <= '0;
      pos_r <= pos_start_r;
      ch_r  <= ch_r + 1'b1;
    end
  end

  assign k   = k_r;
  assign tap = tap_r;
  assign pos = pos_r;

  a_og_le_ss: assert property (@(posedge clk) disable iff (!rst_n) og_r <= ss_r)
    else $error("more outputs than samples");

  a_ss_bound: assert property (@(posedge clk) disable iff (!rst_n) int'(ss_r) <= DEPTH)
    else $error("sample counter past store depth");

  a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK && !emit && final_r) |=> (ss_r == '0 && og_r == '0))
    else $error("counters not cleared at end of run");

  a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |-> (int'(tap_r) <= 2 * int'(k_r)))
    else $error("tap walk past window");

endmodule

// ===== src/binomial_smoother_tapered_ends.sv =====
// An input word with no result goes through the check state and back to ready.
// Each result, with k = window half-width, is formed channel by channel:
// one shared multiply-accumulate walks the 2k+1 taps per channel, then a shared
// radix-2 divider finds the SAMPLE_WIDTH quotient bits. Up to MAX_HALF+1 results per input.
// Throughput: one input word at a time; ready stays low until its results are queued.
// Reset (rst_n low, synchronous): half_width = 1, exclude_center = 0, run cleared.
module binomial_smoother_tapered_ends import bste_pkg::*; #(
  parameter int MAX_HALF     = MAX_HALF_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic        [CFG_IDX_W-1:0]    cfg_index,
  input  logic        [CFG_DATA_W-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_l_value,
  input  logic signed [SAMPLE_WIDTH-1:0] in_a_value,
  input  logic signed [SAMPLE_WIDTH-1:0] in_b_value,
  input  logic                           in_final_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_l_smooth,
  output logic signed [SAMPLE_WIDTH-1:0] out_a_smooth,
  output logic signed [SAMPLE_WIDTH-1:0] out_b_smooth,
  output logic                           out_run_end
);

  localparam int KW = $clog2(MAX_HALF + 1);
  localparam int TW = $clog2(2 * MAX_HALF + 1);
  localparam int PW = $clog2(3 * MAX_HALF + 1);
  localparam int WW = weight_w(MAX_HALF);
  localparam int AW = SAMPLE_WIDTH + WW + 1;

  logic [HALF_W-1:0] half_width_r;
  logic              exclude_r;
  logic [KW-1:0]     h_eff;

  bste_ctl_t                      ctl;
  logic [KW-1:0]                  k;
  logic [TW-1:0]                  tap;
  logic [PW-1:0]                  pos;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic signed [AW-1:0]           acc;
  logic [WW-1:0]                  wsum;
  logic                           div_done;
  logic signed [SAMPLE_WIDTH-1:0] quot;
  logic signed [SAMPLE_WIDTH-1:0] res_r [NUM_CH];
  logic                           out_valid_r;
  logic                           in_fire;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= HALF_W'(1);
      exclude_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_WIDTH: half_width_r <= cfg_data[HALF_W-1:0];
        REG_EXCLUDE:    exclude_r    <= cfg_data[0];
        default:        exclude_r    <= exclude_r;
      endcase
    end
  end

  // Half-widths above MAX_HALF act as MAX_HALF
  assign h_eff   = (int'(half_width_r) > MAX_HALF) ? KW'(MAX_HALF) : KW'(half_width_r);
  assign in_fire = in_valid && in_ready;

  bste_ctrl #(.MAX_HALF(MAX_HALF)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_final  (in_final_sample),
    .h         (h_eff),
    .out_valid (out_valid_r),
    .out_ready (out_ready),
    .div_done  (div_done),
    .ctl       (ctl),
    .k         (k),
    .tap       (tap),
    .pos       (pos)
  );

  bste_window #(.MAX_HALF(MAX_HALF), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_window (
    .clk     (clk),
    .in_fire (in_fire),
    .l_in    (in_l_value),
    .a_in    (in_a_value),
    .b_in    (in_b_value),
    .ch      (ctl.ch),
    .pos     (pos),
    .sample  (sample)
  );

  bste_mac #(.MAX_HALF(MAX_HALF), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .k       (k),
    .tap     (tap),
    .exclude (exclude_r),
    .sample  (sample),
    .acc     (acc),
    .wsum    (wsum)
  );

  bste_div #(.MAX_HALF(MAX_HALF), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .acc   (acc),
    .wsum  (wsum),
    .done  (div_done),
    .quot  (quot)
  );

  // Per-channel results of the word in progress
  always_ff @(posedge clk) begin
    if (ctl.res_load) res_r[ctl.ch] <= quot;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n)             out_valid_r <= 1'b0;
    else if (ctl.out_load)  out_valid_r <= 1'b1;
    else if (out_ready)     out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_l_smooth <= res_r[CH_L];
      out_a_smooth <= res_r[CH_A];
      out_b_smooth <= res_r[CH_B];
      out_run_end  <= ctl.run_end;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sim/binomial_smoother_tapered_ends_test.sv =====
module binomial_smoother_tapered_ends_test;
  import bste_pkg::*;

  localparam int SW    = SAMPLE_WIDTH_DEF;
  localparam int MAXH  = MAX_HALF_DEF;
  localparam int DEPTH = 2 * MAXH + 1;
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  // one input word and one smoothed word
  typedef struct {
    logic signed [SW-1:0] l;
    logic signed [SW-1:0] a;
    logic signed [SW-1:0] b;
    logic                 fin;
  } lab_word_t;

  typedef struct {
    logic signed [SW-1:0] l;
    logic signed [SW-1:0] a;
    logic signed [SW-1:0] b;
    logic                 run_end;
  } smoothed_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [SW-1:0]    in_l_value;
  logic signed [SW-1:0]    in_a_value;
  logic signed [SW-1:0]    in_b_value;
  logic                    in_final_sample;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [SW-1:0]    out_l_smooth;
  logic signed [SW-1:0]    out_a_smooth;
  logic signed [SW-1:0]    out_b_smooth;
  logic                    out_run_end;

  // predictor state
  longint      lab_store [3][DEPTH];
  int          seen_cnt;
  int          given_cnt;
  logic [2:0]  cfg_half;
  logic        cfg_excl;
  smoothed_t   smoothed_q [$];

  int          errors;
  bit          quiet;
  int          hold_req;

  binomial_smoother_tapered_ends u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_l_value      (in_l_value),
    .in_a_value      (in_a_value),
    .in_b_value      (in_b_value),
    .in_final_sample (in_final_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_l_smooth    (out_l_smooth),
    .out_a_smooth    (out_a_smooth),
    .out_b_smooth    (out_b_smooth),
    .out_run_end     (out_run_end)
  );

  // 4-unit clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // weighted binomial mean of one channel around store position centre
  function automatic longint window_mean(int ch, int centre, int k);
    longint sum;
    longint wsum;
    longint c;
    longint w;
    longint unsigned mag;
    longint unsigned q;
    int i;
    int pos;
    sum  = 0;
    wsum = 0;
    c    = 1;
    for (i = 0; i <= 2 * k; i++) begin
      w   = longint'(UNIT_WEIGHT) * c;
      pos = centre + k - i;
      if (cfg_excl && i == k) w = 1;
      if (pos < DEPTH) sum += w * lab_store[ch][pos];
      wsum += w;
      c = c * (2 * k - i) / (i + 1);
    end
    // round half away from zero
    mag = (sum < 0) ? longint'(-sum) : longint'(sum);
    q   = (mag + longint'(wsum) / 2) / longint'(wsum);
    return (sum < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [SW-1:0] clamp_sample(longint v);
    if (v > longint'(S_MAX)) return S_MAX;
    if (v < longint'(S_MIN)) return S_MIN;
    return v[SW-1:0];
  endfunction

  // advance the predictor by one accepted word, queue what it emits
  task automatic predict_word(input lab_word_t w);
    int h;
    int ch;
    int p;
    int cnt;
    int j;
    int from_start;
    int to_end;
    int k;
    int newest;
    bit sat;
    smoothed_t r;
    h = (cfg_half > MAXH) ? MAXH : int'(cfg_half);
    for (ch = 0; ch < 3; ch++) begin
      for (p = DEPTH - 1; p > 0; p--) lab_store[ch][p] = lab_store[ch][p-1];
    end
    lab_store[0][0] = longint'(w.l);
    lab_store[1][0] = longint'(w.a);
    lab_store[2][0] = longint'(w.b);
    if (seen_cnt < DEPTH) seen_cnt++;
    else if (given_cnt > 0) given_cnt--;
    sat    = (seen_cnt >= DEPTH);
    newest = seen_cnt - 1;
    cnt    = 0;
    while (given_cnt < seen_cnt && cnt < MAXH + 1 &&
           (w.fin || seen_cnt - given_cnt > h)) begin
      j          = given_cnt;
      from_start = sat ? MAXH : j;
      to_end     = newest - j;
      k          = (h < from_start) ? h : from_start;
      if (k > to_end) k = to_end;
      r.l       = clamp_sample(window_mean(0, to_end, k));
      r.a       = clamp_sample(window_mean(1, to_end, k));
      r.b       = clamp_sample(window_mean(2, to_end, k));
      r.run_end = w.fin && (j == newest);
      smoothed_q = {smoothed_q, r};
      given_cnt++;
      cnt++;
    end
    if (w.fin) begin
      seen_cnt  = 0;
      given_cnt = 0;
    end
  endtask

  // offer one word, with an occasional idle burst first
  task automatic send_word(input logic signed [SW-1:0] l, input logic signed [SW-1:0] a,
                           input logic signed [SW-1:0] b, input logic fin);
    int gap;
    lab_word_t w;
    w.l   = l;
    w.a   = a;
    w.b   = b;
    w.fin = fin;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_l_value      <= l;
    in_a_value      <= a;
    in_b_value      <= b;
    in_final_sample <= fin;
    do @(posedge clk); while (!in_ready);
    predict_word(w);
  endtask

  // drop valid and let the block drain completely
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HALF_WIDTH) cfg_half = value[2:0];
    else cfg_excl = value[0];
  endtask

  task automatic set_filter(input int half, input int excl);
    wait_idle();
    write_reg(REG_HALF_WIDTH, half);
    write_reg(REG_EXCLUDE, excl);
  endtask

  function automatic logic signed [SW-1:0] rand_channel();
    int t;
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: begin
        t = $urandom_range(0, 16);
        return SW'(t - 8);
      end
      default: return SW'($urandom());
    endcase
  endfunction

  task automatic send_random_run(input int len);
    int i;
    for (i = 0; i < len; i++)
      send_word(rand_channel(), rand_channel(), rand_channel(), i == len - 1);
  endtask

  // reset values: h = 1, normal center weight
  task automatic test_reset_values();
    send_word(S_MAX, S_MIN, 16'sd0, 1'b0);
    send_word(S_MIN, S_MAX, -16'sd1, 1'b1);
  endtask

  // runs shorter than h+1, including a single-sample run
  task automatic test_short_runs();
    set_filter(4, 0);
    send_word(S_MIN, S_MIN, S_MIN, 1'b0);
    send_word(S_MAX, S_MAX, S_MAX, 1'b1);
    send_word(16'sd300, -16'sd300, 16'sd1, 1'b1);
  endtask

  // near-zero center weight, alternating extremes
  task automatic test_exclude_center();
    set_filter(2, 1);
    send_word(S_MAX, S_MIN, S_MAX, 1'b0);
    send_word(S_MIN, S_MAX, S_MIN, 1'b0);
    send_word(S_MAX, S_MIN, 16'sd0, 1'b0);
    send_word(S_MIN, S_MAX, 16'sd5, 1'b1);
  endtask

  // h above the max acts as the max; then h drops mid-run to 0, so the backlog
  // comes out in one burst
  task automatic test_half_width_change();
    set_filter(7, 0);
    send_word(16'sd1000, -16'sd1000, S_MAX, 1'b0);
    send_word(16'sd2000, -16'sd2000, S_MIN, 1'b0);
    send_word(16'sd3000, -16'sd3000, S_MAX, 1'b0);
    send_word(16'sd4000, -16'sd4000, S_MIN, 1'b0);
    set_filter(0, 0);
    send_word(16'sd5000, -16'sd5000, S_MAX, 1'b0);
    send_word(S_MIN, S_MAX, 16'sd0, 1'b1);
  endtask

  // run long enough to saturate the sample counter
  task automatic test_long_run();
    int i;
    set_filter(4, 0);
    for (i = 0; i < 10; i++)
      send_word((i % 2) ? S_MAX : S_MIN, SW'(128 * i), SW'(-77 * i), i == 9);
  endtask

  // receiver holds off long enough for the input to stall
  task automatic test_output_backpressure();
    set_filter(2, 0);
    hold_req = 300;
    send_random_run(12);
    wait_idle();
  endtask

  // random runs and random settings, some changed inside a run
  task automatic test_random_runs();
    int sent;
    int len;
    int i;
    sent = 0;
    while (sent < 48) begin
      if ($urandom_range(0, 1) == 0)
        set_filter($urandom_range(0, 7), $urandom_range(0, 1));
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 9);
      if ($urandom_range(0, 5) == 0 && len > 2) begin
        for (i = 0; i < len; i++) begin
          if (i == len / 2) set_filter($urandom_range(0, 7), $urandom_range(0, 1));
          send_word(rand_channel(), rand_channel(), rand_channel(), i == len - 1);
        end
      end else begin
        send_random_run(len);
      end
      sent += len;
    end
  endtask

  // full rate on both sides
  task automatic test_steady_stream();
    set_filter(3, 0);
    quiet = 1'b1;
    send_random_run(9);
    send_random_run(6);
  endtask

  // receiver: random stall bursts, or a long hold when asked
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        out_ready <= 1'b0;
        repeat (hold_req - 1) @(negedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each accepted output word with the oldest prediction
  always @(posedge clk) begin : result_check
    smoothed_t want;
    if (rst_n && out_valid && out_ready) begin
      if (smoothed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word l=%0d a=%0d b=%0d end=%0b", $time,
                 out_l_smooth, out_a_smooth, out_b_smooth, out_run_end);
      end else begin
        want = smoothed_q.pop_front();
        if (out_l_smooth !== want.l || out_a_smooth !== want.a ||
            out_b_smooth !== want.b || out_run_end !== want.run_end) begin
          errors++;
          $display("%0t: mismatch expected l=%0d a=%0d b=%0d end=%0b", $time,
                   want.l, want.a, want.b, want.run_end);
          $display("%0t:          actual   l=%0d a=%0d b=%0d end=%0b", $time,
                   out_l_smooth, out_a_smooth, out_b_smooth, out_run_end);
        end
      end
    end
  end

  initial begin
    #1600000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int ch;
    int p;
    errors          = 0;
    quiet           = 1'b0;
    hold_req        = 0;
    seen_cnt        = 0;
    given_cnt       = 0;
    cfg_half        = 3'd1;
    cfg_excl        = 1'b0;
    for (ch = 0; ch < 3; ch++)
      for (p = 0; p < DEPTH; p++) lab_store[ch][p] = 0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_HALF_WIDTH;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_l_value      = '0;
    in_a_value      = '0;
    in_b_value      = '0;
    in_final_sample = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_short_runs();
    test_exclude_center();
    test_half_width_change();
    test_long_run();
    test_output_backpressure();
    test_random_runs();
    test_steady_stream();

    @(negedge clk);
    in_valid <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
src/bste_pkg.sv
src/bste_window.sv
src/bste_mac.sv
src/bste_div.sv
src/bste_ctrl.sv
src/binomial_smoother_tapered_ends.sv
sim/binomial_smoother_tapered_ends_test.sv
